/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// Software timer table package
// Operation and status codes and default sizes shared by the cell chain.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int DEFAULT_TIMER_SLOTS = 16;
    localparam int ID_W  = 31;
    localparam int DUR_W = 32;

    localparam logic [2:0] OP_ADD_ONE = 3'd0;
    localparam logic [2:0] OP_ADD_PER = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic             vld;
        logic [2:0]       op;
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
        logic             done;
    } token_t;

    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
        logic            periodic;
    } fire_t;

endpackage

/* src/stt_cell.sv */
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer slot and acts on the command token as it passes by.
// ----------------------------------------------------------------------------
module stt_cell
    import stt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out,
    output fire_t  fire
);

    logic             use_reg;
    logic [ID_W-1:0]  id_reg;
    logic             rel_reg;
    logic [DUR_W-1:0] per_reg;
    logic [DUR_W-1:0] rem_reg;
    logic [DUR_W-1:0] dec;
    logic             hit;
    logic             act;

    assign dec = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign act = tok_in.vld && !tok_in.done;
    assign hit = use_reg && id_reg == tok_in.id;

    always_comb
    begin
        tok_out = tok_in;
        fire = '0;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                OP_ADD_ONE, OP_ADD_PER: if (act && !use_reg) tok_out.done = 1'b1;
                OP_REMOVE, OP_RESTART:  if (act && hit) tok_out.done = 1'b1;
                OP_TICK:
                begin
                    fire.vld = use_reg && dec == '0;
                    fire.id = id_reg;
                    fire.periodic = rel_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_reg <= 1'b0;
        else if (tok_in.vld)
        begin
            case (tok_in.op)
                OP_ADD_ONE, OP_ADD_PER:
                    if (act && !use_reg)
                    begin
                        use_reg <= 1'b1;
                        id_reg  <= tok_in.id;
                        rel_reg <= tok_in.op == OP_ADD_PER;
                        per_reg <= tok_in.dur;
                        rem_reg <= tok_in.dur;
                    end
                OP_REMOVE:  if (act && hit) use_reg <= 1'b0;
                OP_RESTART:
                    if (act && hit)
                    begin
                        per_reg <= tok_in.dur;
                        rem_reg <= tok_in.dur;
                    end
                OP_TICK:
                    if (use_reg)
                    begin
                        if (dec != '0)     rem_reg <= dec;
                        else if (rel_reg)  rem_reg <= per_reg;
                        else               use_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

endmodule

/* src/software_timer_table.sv */
// ----------------------------------------------------------------------------
// Software timer table
// A chain of timer cells with a command token walking from slot to slot.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries operation, lookup_id and duration_ms.
// The command token visits one cell per cycle while the output is not
// stalled, lowest slot first. After the last cell, a drain step issues the
// closing result, and only then is the next item accepted. Add, remove and
// restart give one result transaction. A tick gives one result per fired
// timer, in slot order, or one "nothing due" result. A fired result is
// issued when the next one is found or when the walk ends, so the final one
// carries last. Codes 5 to 7 give no result and leave in_ready high.
// in_ready is low while an item walks the chain. When the receiver stalls,
// the walk holds until the output register is taken. Reset frees every slot
// and clears the id counter; the block is ready right away.
// ----------------------------------------------------------------------------
module software_timer_table
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEFAULT_TIMER_SLOTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       operation,
    input  logic [ID_W-1:0]  lookup_id,
    input  logic [DUR_W-1:0] duration_ms,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  result_id,
    output logic             fired,
    output logic             was_periodic,
    output logic             last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic            busy_reg;
    logic            busy_next;
    logic            drain_reg;
    logic            drain_next;
    logic [SW-1:0]   pos_reg;
    logic [SW-1:0]   pos_next;
    token_t          tok_reg;
    token_t          tok_next;
    logic [ID_W-1:0] lid_reg;
    logic [ID_W-1:0] lid_next;
    logic            hold_vld_reg;
    logic            hold_vld_next;
    logic [ID_W-1:0] hold_id_reg;
    logic [ID_W-1:0] hold_id_next;
    logic            hold_per_reg;
    logic            hold_per_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [ID_W-1:0] result_id_reg;
    logic [ID_W-1:0] result_id_next;
    logic            fired_reg;
    logic            fired_next;
    logic            periodic_reg;
    logic            periodic_next;
    logic            last_reg;
    logic            last_next;
    logic [ID_W-1:0] nid;
    token_t          t_in  [TIMER_SLOTS];
    token_t          t_out [TIMER_SLOTS];
    fire_t           f     [TIMER_SLOTS];
    token_t          cur_out;
    fire_t           cur_f;
    logic            step;
    logic            walk;
    logic            fin;
    logic            in_add;
    logic            tok_add;

    assign nid = (lid_reg == {ID_W{1'b1}}) ? ID_W'(1) : lid_reg + 1'b1;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            always_comb
            begin
                t_in[g] = tok_reg;
                t_in[g].vld = tok_reg.vld && walk && pos_reg == SW'(g);
            end
            stt_cell u_cell (.clk(clk), .rst_n(rst_n), .tok_in(t_in[g]),
                             .tok_out(t_out[g]), .fire(f[g]));
        end
    endgenerate

    assign cur_out  = t_out[pos_reg];
    assign cur_f    = f[pos_reg];
    assign step     = busy_reg && (!out_valid_reg || out_ready);
    assign walk     = step && !drain_reg;
    assign fin      = pos_reg == SW'(TIMER_SLOTS - 1);
    assign in_ready = !busy_reg;
    assign in_add   = operation == OP_ADD_ONE || operation == OP_ADD_PER;
    assign tok_add  = tok_reg.op == OP_ADD_ONE || tok_reg.op == OP_ADD_PER;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_id    = result_id_reg;
    assign fired        = fired_reg;
    assign was_periodic = periodic_reg;
    assign last         = last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        drain_next     = drain_reg;
        pos_next       = pos_reg;
        tok_next       = tok_reg;
        lid_next       = lid_reg;
        hold_vld_next  = hold_vld_reg;
        hold_id_next   = hold_id_reg;
        hold_per_next  = hold_per_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        result_id_next = result_id_reg;
        fired_next     = fired_reg;
        periodic_next  = periodic_reg;
        last_next      = last_reg;
        if (in_valid && in_ready)
        begin
            busy_next     = operation <= OP_TICK;
            drain_next    = 1'b0;
            pos_next      = '0;
            hold_vld_next = 1'b0;
            tok_next.vld  = 1'b1;
            tok_next.op   = operation;
            tok_next.dur  = duration_ms;
            tok_next.done = 1'b0;
            tok_next.id   = in_add ? nid : lookup_id;
        end
        else if (step)
        begin
            if (drain_reg)
            begin
                busy_next      = 1'b0;
                drain_next     = 1'b0;
                out_valid_next = 1'b1;
                result_id_next = '0;
                fired_next     = 1'b0;
                periodic_next  = 1'b0;
                last_next      = 1'b1;
                if (tok_reg.op == OP_TICK)
                begin
                    hold_vld_next = 1'b0;
                    if (hold_vld_reg)
                    begin
                        status_next    = ST_OK;
                        result_id_next = hold_id_reg;
                        fired_next     = 1'b1;
                        periodic_next  = hold_per_reg;
                    end
                    else
                        status_next = ST_NONE;
                end
                else if (tok_add)
                begin
                    if (tok_reg.done)
                    begin
                        status_next    = ST_OK;
                        result_id_next = tok_reg.id;
                        lid_next       = tok_reg.id;
                    end
                    else
                        status_next = ST_FULL;
                end
                else
                    status_next = tok_reg.done ? ST_OK : ST_NOTFOUND;
            end
            else
            begin
                tok_next.done = cur_out.done;
                if (fin)
                    drain_next = 1'b1;
                else
                    pos_next = pos_reg + 1'b1;
                if (tok_reg.op == OP_TICK && cur_f.vld)
                begin
                    hold_vld_next = 1'b1;
                    hold_id_next  = cur_f.id;
                    hold_per_next = cur_f.periodic;
                    if (hold_vld_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        result_id_next = hold_id_reg;
                        fired_next     = 1'b1;
                        periodic_next  = hold_per_reg;
                        last_next      = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            drain_reg     <= 1'b0;
            pos_reg       <= '0;
            tok_reg       <= '0;
            lid_reg       <= '0;
            hold_vld_reg  <= 1'b0;
            hold_id_reg   <= '0;
            hold_per_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            result_id_reg <= '0;
            fired_reg     <= 1'b0;
            periodic_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            drain_reg     <= drain_next;
            pos_reg       <= pos_next;
            tok_reg       <= tok_next;
            lid_reg       <= lid_next;
            hold_vld_reg  <= hold_vld_next;
            hold_id_reg   <= hold_id_next;
            hold_per_reg  <= hold_per_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            result_id_reg <= result_id_next;
            fired_reg     <= fired_next;
            periodic_reg  <= periodic_next;
            last_reg      <= last_next;
        end
    end

endmodule

/* dv/tb_software_timer_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives add, remove, restart, tick and unused-code transactions with random
// bursts and output stalls, predicts every result from a cycle-free model of
// the timer slots, and checks each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_software_timer_table;
    import stt_pkg::*;

    localparam int SLOTS = DEFAULT_TIMER_SLOTS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]      status;
        logic [ID_W-1:0] id;
        logic            fired;
        logic            periodic;
        logic            last;
    } timer_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       operation;
    logic [ID_W-1:0]  lookup_id;
    logic [DUR_W-1:0] duration_ms;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  result_id;
    logic             fired;
    logic             was_periodic;
    logic             last;

    logic             slot_busy [SLOTS];
    logic [ID_W-1:0]  slot_id [SLOTS];
    logic             slot_periodic [SLOTS];
    logic [DUR_W-1:0] slot_period [SLOTS];
    logic [DUR_W-1:0] slot_left [SLOTS];
    logic [ID_W-1:0]  newest_id;

    timer_result_t pending_results[$];
    int            mismatches;
    int            cycles;
    bit            hold_request;
    bit            hold_active;

    software_timer_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .lookup_id    (lookup_id),
        .duration_ms  (duration_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_id    (result_id),
        .fired        (fired),
        .was_periodic (was_periodic),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void push_result(logic [1:0] st, logic [ID_W-1:0] id,
                                        logic f, logic p, logic l);
        timer_result_t r;
        r.status   = st;
        r.id       = id;
        r.fired    = f;
        r.periodic = p;
        r.last     = l;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_timers(logic [2:0] op, logic [ID_W-1:0] id,
                                           logic [DUR_W-1:0] dur);
        int hit;
        int count;
        hit = -1;
        count = 0;
        if (op == OP_ADD_ONE || op == OP_ADD_PER)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (!slot_busy[i] && hit < 0)
                    hit = i;
            if (hit < 0)
                push_result(ST_FULL, '0, 1'b0, 1'b0, 1'b1);
            else
            begin
                newest_id = newest_id + 1'b1;
                if (newest_id == '0)
                    newest_id = ID_W'(1);
                slot_busy[hit]     = 1'b1;
                slot_id[hit]       = newest_id;
                slot_periodic[hit] = (op == OP_ADD_PER);
                slot_period[hit]   = dur;
                slot_left[hit]     = dur;
                push_result(ST_OK, newest_id, 1'b0, 1'b0, 1'b1);
            end
        end
        else if (op == OP_REMOVE || op == OP_RESTART)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy[i] && slot_id[i] == id && hit < 0)
                    hit = i;
            if (hit < 0)
                push_result(ST_NOTFOUND, '0, 1'b0, 1'b0, 1'b1);
            else
            begin
                if (op == OP_REMOVE)
                    slot_busy[hit] = 1'b0;
                else
                begin
                    slot_period[hit] = dur;
                    slot_left[hit]   = dur;
                end
                push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
            end
        end
        else if (op == OP_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_busy[i])
                begin
                    if (slot_left[i] != '0)
                        slot_left[i]--;
                    if (slot_left[i] == '0)
                    begin
                        push_result(ST_OK, slot_id[i], 1'b1, slot_periodic[i], 1'b0);
                        count++;
                        if (slot_periodic[i])
                            slot_left[i] = slot_period[i];
                        else
                            slot_busy[i] = 1'b0;
                    end
                end
            end
            if (count == 0)
                push_result(ST_NONE, '0, 1'b0, 1'b0, 1'b1);
            else
                pending_results[$].last = 1'b1;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high so that a following item keeps it asserted.
    task automatic send_item(logic [2:0] op, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
        in_valid    <= 1'b1;
        operation   <= op;
        lookup_id   <= id;
        duration_ms <= dur;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_timers(op, id, dur);
        @(negedge clk);
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SLOTS + 4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        timer_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d id %0d", status, result_id);
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    mismatches++;
                end
                if (result_id !== e.id)
                begin
                    $error("result_id: expected %0d, actual %0d", e.id, result_id);
                    mismatches++;
                end
                if (fired !== e.fired)
                begin
                    $error("fired: expected %0d, actual %0d", e.fired, fired);
                    mismatches++;
                end
                if (was_periodic !== e.periodic)
                begin
                    $error("was_periodic: expected %0d, actual %0d", e.periodic,
                           was_periodic);
                    mismatches++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int mode;
        int held;
        mode = (cycles / 97) % 4;
        if (hold_request && !hold_active)
        begin
            hold_active = 1'b1;
            held = 0;
        end
        if (hold_active)
        begin
            out_ready <= 1'b0;
            held++;
            if (held >= HOLD_CYCLES)
            begin
                hold_active  = 1'b0;
                hold_request = 1'b0;
            end
        end
        else if (mode == 0)
            out_ready <= 1'b1;
        else if (mode == 1)
            out_ready <= ($urandom_range(0, 1) == 1);
        else if (mode == 2)
            out_ready <= ($urandom_range(0, 3) == 0);
        else
            out_ready <= ($urandom_range(0, 7) != 0);
    end

    function automatic logic [ID_W-1:0] pick_id();
        int lo;
        if ($urandom_range(0, 9) == 0 || newest_id == '0)
            return ID_W'($urandom());
        lo = (newest_id > 24) ? int'(newest_id) - 24 : 1;
        return ID_W'($urandom_range(lo, int'(newest_id)));
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return $urandom();
        if (sel == 1)
            return '1;
        return $urandom_range(0, 6);
    endfunction

    task automatic test_add_and_full();
        send_item(OP_ADD_ONE, '0, '0);
        send_item(OP_ADD_PER, '1, '1);
        send_item(OP_ADD_PER, '0, '0);
        for (int i = 3; i < SLOTS; i++)
            send_item(OP_ADD_PER, '0, 2);
        send_item(OP_ADD_ONE, '0, 1);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        wait_all_results();
    endtask

    task automatic test_remove_and_restart();
        send_item(OP_REMOVE, ID_W'(2), '0);
        send_item(OP_RESTART, ID_W'(2), 5);
        send_item(OP_RESTART, ID_W'(3), 1);
        send_item(OP_REMOVE, '1, '0);
        send_item(OP_RESTART, '0, '1);
        for (int i = 4; i <= SLOTS; i++)
            send_item(OP_REMOVE, ID_W'(i), '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        wait_all_results();
    endtask

    task automatic test_unused_codes();
        send_item(3'd5, '1, '1);
        send_item(3'd6, '0, '0);
        send_item(3'd7, '1, '0);
        send_item(OP_TICK, '0, '0);
        wait_all_results();
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(OP_ADD_PER, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        wait_all_results();
    endtask

    task automatic test_random_traffic(int items);
        int burst;
        int sel;
        logic [2:0] op;
        burst = 0;
        for (int n = 0; n < items; n++)
        begin
            if (burst == 0)
            begin
                idle_sender($urandom_range(1, 12));
                burst = $urandom_range(1, 20);
            end
            burst--;
            sel = $urandom_range(0, 99);
            if (sel < 25)
                op = OP_ADD_ONE;
            else if (sel < 40)
                op = OP_ADD_PER;
            else if (sel < 52)
                op = OP_REMOVE;
            else if (sel < 62)
                op = OP_RESTART;
            else if (sel < 97)
                op = OP_TICK;
            else
                op = 3'($urandom_range(5, 7));
            send_item(op, pick_id(), pick_duration());
            if (n == items / 2)
                wait_all_results();
        end
        wait_all_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = '0;
        lookup_id    = '0;
        duration_ms  = '0;
        out_ready    = 1'b0;
        mismatches   = 0;
        cycles       = 0;
        hold_request = 1'b0;
        hold_active  = 1'b0;
        newest_id    = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]     = 1'b0;
            slot_id[i]       = '0;
            slot_periodic[i] = 1'b0;
            slot_period[i]   = '0;
            slot_left[i]     = '0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_add_and_full();
        test_remove_and_restart();
        test_unused_codes();
        test_output_stall();
        test_random_traffic(320);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/stt_pkg.sv
src/stt_cell.sv
src/software_timer_table.sv
dv/tb_software_timer_table.sv
